// ===== rtl/core/four_level_page_table_walker_macros.svh =====
// ---------------------------------------------------------------------------
// four_level_page_table_walker_macros
// Assertion macros used by the walker controller; empty under synthesis.
// ---------------------------------------------------------------------------
`ifndef FOUR_LEVEL_PAGE_TABLE_WALKER_MACROS_SVH
`define FOUR_LEVEL_PAGE_TABLE_WALKER_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked on clk and quiet during rst
`define PTW_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ptw assertion failed");
// next-cycle implication, checked on clk and quiet during rst
`define PTW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ptw assertion failed");
`else
`define PTW_ASSERT_NOW(label, ante, cons)
`define PTW_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== rtl/core/ptw_pkg.sv =====
// ---------------------------------------------------------------------------
// ptw_pkg
// Shared constants, types and helpers of the four-level page table walker.
// ---------------------------------------------------------------------------
`default_nettype none

package ptw_pkg;

  // table store geometry (page count is a power of two)
  localparam int TABLE_PAGES = 8;
  localparam int ENTRIES     = TABLE_PAGES * 512;
  localparam int ADDR_W      = $clog2(ENTRIES);
  localparam int PAGE_W      = $clog2(TABLE_PAGES);
  localparam int IDX_W       = 9;

  // field widths
  localparam int ENTRY_W = 64;
  localparam int VA_W    = 48;
  localparam int PA_W    = 52;
  localparam int PN_W    = 40;
  localparam int STS_W   = 3;
  localparam int ROOT_W  = 3;
  localparam int SLOT_W  = 12;

  // entry bit positions
  localparam int BIT_PRESENT = 0;
  localparam int BIT_HUGE    = 7;

  // configuration register index
  localparam logic REG_ROOT_TABLE = 1'b0;

  // request types
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_XLATE = 1'b1;

  // result forms
  localparam logic [1:0] RES_ZERO   = 2'd0;
  localparam logic [1:0] RES_GIG    = 2'd1;
  localparam logic [1:0] RES_TWOMEG = 2'd2;
  localparam logic [1:0] RES_PAGE   = 2'd3;

  localparam logic [STS_W-1:0] STS_OK = 3'd0;

  // controller to datapath commands
  typedef struct packed {
    logic             clr_step;
    logic             wr_entry;
    logic             rd_root;
    logic             rd_next;
    logic [1:0]       lvl;
    logic             set_result;
    logic [1:0]       res_kind;
    logic [STS_W-1:0] res_status;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic clr_last;
    logic present;
    logic huge;
  } sts_t;

  // store page from a page number, modulo the page count
  function automatic logic [PAGE_W-1:0] page_sel(input logic [PN_W-1:0] pn);
    page_sel = pn[PAGE_W-1:0];
  endfunction

  // table index of a walk level, level 0 being the top
  function automatic logic [IDX_W-1:0] idx_of(input logic [VA_W-1:0] va,
                                              input logic [1:0] lvl);
    unique case (lvl)
      2'd0:    idx_of = va[47:39];
      2'd1:    idx_of = va[38:30];
      2'd2:    idx_of = va[29:21];
      default: idx_of = va[20:12];
    endcase
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/four_level_page_table_walker.sv =====
// ---------------------------------------------------------------------------
// four_level_page_table_walker
// Four-level 48-bit address translation over an on-chip table store.
// ---------------------------------------------------------------------------
// Usage: an item is taken at a clock edge with start high and busy low.
// req_type low writes entry_word into store slot entry_slot; high translates
// vaddr. Every item gives one result on xlat_addr and status, shown for
// one cycle with done high; the receiver cannot stall and must take it then.
// An entry write is stored when taken; its result follows in the next cycle;
// busy stays low, so writes can be issued every cycle.
// A translation does one dependent store read per level, as the store
// returns registered data: busy stays high until the last level is
// decoded, and done rises the cycle after the last level.
// root_table is set through the APB port at address 0; the user sets it only
// while the block idles; the block does not enforce it. After reset, the
// store is zeroed one entry a cycle, busy high; register writes are taken.
// ---------------------------------------------------------------------------
`default_nettype none

module four_level_page_table_walker (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // item channel
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          req_type,
  input  wire logic [ptw_pkg::SLOT_W-1:0]    entry_slot,
  input  wire logic [ptw_pkg::ENTRY_W-1:0]   entry_word,
  input  wire logic [ptw_pkg::VA_W-1:0]      vaddr,
  // result channel
  output logic                               done,
  output logic [ptw_pkg::PA_W-1:0]           xlat_addr,
  output logic [ptw_pkg::STS_W-1:0]          status,
  // configuration port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [2:0]                    paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  logic [ptw_pkg::ROOT_W-1:0] root_table;
  ptw_pkg::cmd_t              cmd;
  ptw_pkg::sts_t              sts;

  assign pready = 1'b1;

  // root table register
  always_ff @(posedge clk) begin
    if (rst) begin
      root_table <= '0;
    end else if (psel && penable && pwrite && pready && paddr[2] == ptw_pkg::REG_ROOT_TABLE) begin
      root_table <= pwdata[ptw_pkg::ROOT_W-1:0];
    end
  end

  // register read back
  always_comb begin
    unique case (paddr[2])
      ptw_pkg::REG_ROOT_TABLE: prdata = {{(32 - ptw_pkg::ROOT_W){1'b0}}, root_table};
      default:                 prdata = '0;
    endcase
  end

  ptw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_type (req_type),
    .sts      (sts),
    .cmd      (cmd),
    .busy     (busy)
  );

  ptw_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .root_table (root_table),
    .entry_slot (entry_slot),
    .entry_word (entry_word),
    .vaddr      (vaddr),
    .sts        (sts),
    .done       (done),
    .xlat_addr  (xlat_addr),
    .status     (status)
  );

endmodule

`default_nettype wire

// ===== rtl/core/ptw_ram.sv =====
// ---------------------------------------------------------------------------
// ptw_ram
// Generic single-port RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module ptw_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write or read one word a cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/ptw_ctrl.sv =====
// ---------------------------------------------------------------------------
// ptw_ctrl
// Walk sequencer: clearing pass, entry writes and the level-by-level walk.
// ---------------------------------------------------------------------------
`default_nettype none
`include "four_level_page_table_walker_macros.svh"

module ptw_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic          req_type,
  input  wire ptw_pkg::sts_t sts,
  output ptw_pkg::cmd_t      cmd,
  output logic               busy
);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_WALK  = 2'd2;

  logic [1:0] state, state_next;
  logic [1:0] lvl, lvl_next;

  assign busy = (state != S_IDLE);

  // state and level registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      lvl   <= 2'd0;
    end else begin
      state <= state_next;
      lvl   <= lvl_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    lvl_next   = lvl;
    cmd        = '0;
    cmd.lvl    = lvl;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          if (req_type == ptw_pkg::REQ_WRITE) begin
            cmd.wr_entry   = 1'b1;
            cmd.set_result = 1'b1;
            cmd.res_kind   = ptw_pkg::RES_ZERO;
            cmd.res_status = ptw_pkg::STS_OK;
          end else begin
            cmd.rd_root = 1'b1;
            lvl_next    = 2'd0;
            state_next  = S_WALK;
          end
        end
      end
      S_WALK: begin
        if (!sts.present) begin
          // fault names the level, one-based
          cmd.set_result = 1'b1;
          cmd.res_kind   = ptw_pkg::RES_ZERO;
          cmd.res_status = {1'b0, lvl} + 3'd1;
          state_next     = S_IDLE;
        end else if (lvl == 2'd1 && sts.huge) begin
          cmd.set_result = 1'b1;
          cmd.res_kind   = ptw_pkg::RES_GIG;
          cmd.res_status = ptw_pkg::STS_OK;
          state_next     = S_IDLE;
        end else if (lvl == 2'd2 && sts.huge) begin
          cmd.set_result = 1'b1;
          cmd.res_kind   = ptw_pkg::RES_TWOMEG;
          cmd.res_status = ptw_pkg::STS_OK;
          state_next     = S_IDLE;
        end else if (lvl == 2'd3) begin
          cmd.set_result = 1'b1;
          cmd.res_kind   = ptw_pkg::RES_PAGE;
          cmd.res_status = ptw_pkg::STS_OK;
          state_next     = S_IDLE;
        end else begin
          cmd.rd_next = 1'b1;
          lvl_next    = lvl + 2'd1;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  // a translate request always starts the walk at the top level
  `PTW_ASSERT_NEXT(a_walk_start, state == S_IDLE && start && req_type == ptw_pkg::REQ_XLATE, state == S_WALK && lvl == 2'd0)
  // each walk cycle either reads deeper or finishes, never both
  `PTW_ASSERT_NOW(a_walk_step, state == S_WALK, $onehot({cmd.rd_next, cmd.set_result}))
  // the clearing pass runs to the last entry before any item is taken
  `PTW_ASSERT_NEXT(a_clear_hold, state == S_CLEAR && !sts.clr_last, state == S_CLEAR && busy)
  // the walk never goes below the last level
  `PTW_ASSERT_NOW(a_last_level, state == S_WALK && lvl == 2'd3, !cmd.rd_next)

endmodule

`default_nettype wire

// ===== rtl/core/ptw_datapath.sv =====
// ---------------------------------------------------------------------------
// ptw_datapath
// Table store, address selection, entry decode and result registers.
// ---------------------------------------------------------------------------
`default_nettype none

module ptw_datapath (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire ptw_pkg::cmd_t                         cmd,
  input  wire logic [ptw_pkg::ROOT_W-1:0]            root_table,
  input  wire logic [ptw_pkg::SLOT_W-1:0]            entry_slot,
  input  wire logic [ptw_pkg::ENTRY_W-1:0]           entry_word,
  input  wire logic [ptw_pkg::VA_W-1:0]              vaddr,
  output ptw_pkg::sts_t                              sts,
  output logic                                       done,
  output logic [ptw_pkg::PA_W-1:0]                   xlat_addr,
  output logic [ptw_pkg::STS_W-1:0]                  status
);

  logic [ptw_pkg::ADDR_W-1:0]  clr_addr;
  logic [ptw_pkg::VA_W-1:0]    va;
  logic [ptw_pkg::ADDR_W-1:0]  ram_addr;
  logic                        ram_we;
  logic [ptw_pkg::ENTRY_W-1:0] ram_wdata;
  logic [ptw_pkg::ENTRY_W-1:0] entry;
  logic [ptw_pkg::PA_W-1:0]    phys_res;

  // clearing pass counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_step) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // address latched for the walk
  always_ff @(posedge clk) begin
    if (cmd.rd_root) begin
      va <= vaddr;
    end
  end

  // store port selection
  always_comb begin
    ram_we    = cmd.clr_step | cmd.wr_entry;
    ram_wdata = cmd.wr_entry ? entry_word : '0;
    if (cmd.clr_step) begin
      ram_addr = clr_addr;
    end else if (cmd.wr_entry) begin
      ram_addr = {ptw_pkg::page_sel(ptw_pkg::PN_W'(entry_slot[11:9])), entry_slot[8:0]};
    end else if (cmd.rd_root) begin
      ram_addr = {ptw_pkg::page_sel(ptw_pkg::PN_W'(root_table)),
                  ptw_pkg::idx_of(vaddr, 2'd0)};
    end else begin
      ram_addr = {ptw_pkg::page_sel(entry[51:12]), ptw_pkg::idx_of(va, cmd.lvl + 2'd1)};
    end
  end

  ptw_ram #(
    .WIDTH (ptw_pkg::ENTRY_W),
    .DEPTH (ptw_pkg::ENTRIES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (entry)
  );

  // entry decode
  assign sts.clr_last = (clr_addr == {ptw_pkg::ADDR_W{1'b1}});
  assign sts.present  = entry[ptw_pkg::BIT_PRESENT];
  assign sts.huge     = entry[ptw_pkg::BIT_HUGE];

  // physical address by mapping size
  always_comb begin
    case (cmd.res_kind)
      ptw_pkg::RES_GIG:    phys_res = {entry[51:30], va[29:0]};
      ptw_pkg::RES_TWOMEG: phys_res = {entry[51:21], va[20:0]};
      ptw_pkg::RES_PAGE:   phys_res = {entry[51:12], va[11:0]};
      default:             phys_res = '0;
    endcase
  end

  // result registers and strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.set_result;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set_result) begin
      xlat_addr <= phys_res;
      status    <= cmd.res_status;
    end
  end

endmodule

`default_nettype wire
